FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file gfa_checker.sv.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define GFA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define GFA_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/gfa_pkg.sv
// Shared types, widths and constants of the layout force accumulator.
// No dependencies; every other file but assert_macros.svh imports it.
package gfa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int MAX_NODES = 1024;

  localparam int IDX_W  = 10;
  localparam int POS_W  = 24;
  localparam int RAD_W  = 16;
  localparam int TD_W   = 24;
  localparam int CNT_W  = 11;
  localparam int SUM_W  = 40;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 80;
  localparam int ADDR_W      = 5;

  localparam int D_W    = POS_W + 1;        // signed coordinate difference
  localparam int SQ_W   = 2 * POS_W + 1;    // one square
  localparam int DSQ_W  = 2 * POS_W + 2;    // sum of two squares
  localparam int TT_W   = 2 * TD_W;         // target distance squared
  localparam int RT_W   = DSQ_W / 2;        // square root width
  localparam int DVN_W  = DSQ_W + 1;        // divider dividend and quotient
  localparam int DVD_W  = D_W;              // divider divisor
  localparam int NM1_W  = CNT_W - 1;
  localparam int U_SH   = 16;               // unit vector fraction bits
  localparam int U_W    = U_SH + 2;
  localparam int F_W    = 48;
  localparam int PROD_W = F_W + U_W;
  localparam int CON_W  = 48;
  localparam int SQRT_STEPS = RT_W;
  localparam int DIV_STEPS  = DVN_W;
  localparam int SQC_W  = $clog2(SQRT_STEPS);
  localparam int DVC_W  = $clog2(DIV_STEPS);

  // Target distances below 0.01 are ignored.
  localparam logic [TD_W-1:0] T_MIN = TD_W'(((1 << FRAC_BITS) + 99) / 100);
  // Touching margin of 2.0 in fixed point.
  localparam logic [RAD_W:0] TOUCH_OFS = (RAD_W+1)'(2 << FRAC_BITS);
  localparam logic [DVN_W-1:0] F_LIM = DVN_W'(1) << 46;
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NODES);

  localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'(64'sd549755813887);
  localparam logic signed [SUM_W:0] SUM_MIN = (SUM_W+1)'(-64'sd549755813888);

  localparam logic [2:0] REG_SELF_X   = 3'd0;
  localparam logic [2:0] REG_SELF_Y   = 3'd1;
  localparam logic [2:0] REG_SELF_RAD = 3'd2;
  localparam logic [2:0] REG_SELF_IDX = 3'd3;
  localparam logic [2:0] REG_COUNT    = 3'd4;

  typedef enum logic [2:0] {
    DSEL_A  = 3'd0,   // distance squared over target
    DSEL_B  = 3'd1,   // target squared over distance
    DSEL_F  = 3'd2,   // force over count minus one
    DSEL_UX = 3'd3,   // x unit component
    DSEL_UY = 3'd4    // y unit component
  } dsel_t;

  typedef struct packed {
    logic signed [POS_W-1:0] self_x;
    logic signed [POS_W-1:0] self_y;
    logic [RAD_W-1:0]        self_radius;
    logic [IDX_W-1:0]        self_index;
    logic [CNT_W-1:0]        node_count;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  diff;
    logic  square;
    logic  sum;
    logic  sqrt_start;
    logic  div_start;
    logic  div_store;
    dsel_t dsel;
    logic  mul;
    logic  acc;
    logic  use_y;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic skip_early;
    logic dsq_zero;
    logic touching;
    logic sqrt_done;
    logic div_done;
    logic last;
  } stat_t;

endpackage

FILE: rtl/gfa_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gfa_pkg for its widths.
module gfa_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [gfa_pkg::DVN_W-1:0] dividend,
  input  logic [gfa_pkg::DVD_W-1:0] divisor,
  output logic [gfa_pkg::DVN_W-1:0] quotient,
  output logic                     done
);
  import gfa_pkg::*;

  logic             busy;
  logic [DVC_W-1:0] cnt;
  logic [DVD_W-1:0] den;
  logic [DVD_W-1:0] rem;
  logic [DVN_W-1:0] acc;
  logic [DVD_W:0]   rem_sh;
  logic [DVD_W:0]   rem_sub;
  logic             fits;

  assign rem_sh  = {rem, acc[DVN_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign fits    = rem_sh >= {1'b0, den};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DVC_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? rem_sub[DVD_W-1:0] : rem_sh[DVD_W-1:0];
      acc <= {acc[DVN_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/gfa_dp.sv
// Datapath: operand registers, squares, square root, divider, multiplier
// and the saturating accumulators. Depends on gfa_pkg and gfa_div.
module gfa_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  gfa_pkg::cfg_t                 cfg,
  input  gfa_pkg::cmd_t                 cmd,
  output gfa_pkg::stat_t                stat,
  input  logic [gfa_pkg::IN_TDATA_W-1:0] in_data,
  input  logic                          in_last,
  output logic [gfa_pkg::OUT_TDATA_W-1:0] out_data
);
  import gfa_pkg::*;

  // Captured item.
  logic [IDX_W-1:0]        idx;
  logic signed [POS_W-1:0] ox;
  logic signed [POS_W-1:0] oy;
  logic [RAD_W-1:0]        orad;
  logic [TD_W-1:0]         t;
  logic                    last;

  logic signed [D_W-1:0] dx;
  logic signed [D_W-1:0] dy;
  logic [SQ_W-1:0]       dx2;
  logic [SQ_W-1:0]       dy2;
  logic [TT_W-1:0]       tt;
  logic [DSQ_W-1:0]      dsq;

  // Square root state.
  logic             sq_busy;
  logic             sq_done;
  logic [SQC_W-1:0] sq_cnt;
  logic [DSQ_W-1:0] sq_v;
  logic [RT_W:0]    sq_rem;
  logic [RT_W-1:0]  d;
  logic [RT_W+2:0]  sq_rsh;
  logic [RT_W+2:0]  sq_trial;
  logic             sq_fits;
  logic [RT_W+2:0]  sq_sub;

  // Division operands and results.
  logic [DVN_W-1:0]        dv_n;
  logic [DVD_W-1:0]        dv_d;
  logic [DVN_W-1:0]        dv_q;
  logic                    dv_done;
  logic [DSQ_W-1:0]        a_q;
  logic [TT_W-1:0]         b_q;
  logic signed [DVN_W-1:0] diff;
  logic [DVN_W-1:0]        diff_mag;
  logic [D_W-1:0]          adx;
  logic [D_W-1:0]          ady;
  logic [CNT_W-1:0]        n_eff;
  logic [NM1_W-1:0]        nm1;
  logic [DVN_W-1:0]        f_mag;
  logic signed [F_W-1:0]   f;
  logic signed [U_W-1:0]   ux;
  logic signed [U_W-1:0]   uy;
  logic signed [U_W-1:0]   u_q;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [CON_W-1:0]  contrib;
  logic signed [SUM_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]  sum_y;
  logic signed [SUM_W-1:0]  sum_sel;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [CON_W:0]    sum_raw;
  logic signed [SUM_W-1:0]  sum_sat;
  logic [RAD_W:0]           thr;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx  <= in_data[9:0];
      ox   <= in_data[33:10];
      oy   <= in_data[57:34];
      orad <= in_data[73:58];
      t    <= in_data[97:74];
      last <= in_last;
    end
    if (cmd.diff) begin
      dx <= D_W'(ox) - D_W'(cfg.self_x);
      dy <= D_W'(oy) - D_W'(cfg.self_y);
    end
    if (cmd.square) begin
      dx2 <= SQ_W'(dx * dx);
      dy2 <= SQ_W'(dy * dy);
      tt  <= TT_W'(t) * TT_W'(t);
    end
    if (cmd.sum) begin
      dsq <= DSQ_W'(dx2) + DSQ_W'(dy2);
    end
  end

  always_comb begin
    if (cfg.node_count < CNT_MIN) begin
      n_eff = CNT_MIN;
    end else if (cfg.node_count > CNT_MAX) begin
      n_eff = CNT_MAX;
    end else begin
      n_eff = cfg.node_count;
    end
  end
  assign nm1 = NM1_W'(n_eff - 1'b1);

  assign thr = {1'b0, cfg.self_radius} + {1'b0, orad};

  assign stat.skip_early = (idx == cfg.self_index) || ({1'b0, idx} >= n_eff) || (t < T_MIN);
  assign stat.dsq_zero   = (dsq == '0);
  assign stat.touching   = (thr >= TOUCH_OFS) && (d < RT_W'(thr - TOUCH_OFS));
  assign stat.sqrt_done  = sq_done;
  assign stat.div_done   = dv_done;
  assign stat.last       = last;

  // Digit-by-digit square root, two radicand bits per cycle.
  assign sq_rsh   = {sq_rem, sq_v[DSQ_W-1 -: 2]};
  assign sq_trial = {1'b0, d, 2'b01};
  assign sq_fits  = sq_rsh >= sq_trial;
  assign sq_sub   = sq_rsh - sq_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
      sq_cnt  <= '0;
    end else begin
      sq_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_busy <= 1'b1;
        sq_cnt  <= '0;
      end else if (sq_busy) begin
        sq_cnt <= sq_cnt + 1'b1;
        if (sq_cnt == SQC_W'(SQRT_STEPS - 1)) begin
          sq_busy <= 1'b0;
          sq_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_v   <= dsq;
      sq_rem <= '0;
      d      <= '0;
    end else if (sq_busy) begin
      sq_v   <= {sq_v[DSQ_W-3:0], 2'b00};
      sq_rem <= sq_fits ? sq_sub[RT_W:0] : sq_rsh[RT_W:0];
      d      <= {d[RT_W-2:0], sq_fits};
    end
  end

  // Operand selection for the shared divider.
  assign diff     = $signed({1'b0, a_q}) - $signed({3'b000, b_q});
  assign diff_mag = diff[DVN_W-1] ? DVN_W'(-diff) : DVN_W'(diff);
  assign adx      = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
  assign ady      = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);

  always_comb begin
    case (cmd.dsel)
      DSEL_A: begin
        dv_n = DVN_W'(dsq);
        dv_d = DVD_W'(t);
      end
      DSEL_B: begin
        dv_n = DVN_W'(tt);
        dv_d = DVD_W'(d);
      end
      DSEL_F: begin
        dv_n = diff_mag;
        dv_d = DVD_W'(nm1);
      end
      DSEL_UX: begin
        dv_n = DVN_W'({adx, 16'h0000});
        dv_d = DVD_W'(d);
      end
      DSEL_UY: begin
        dv_n = DVN_W'({ady, 16'h0000});
        dv_d = DVD_W'(d);
      end
      default: begin
        dv_n = '0;
        dv_d = DVD_W'(1);
      end
    endcase
  end

  gfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dv_n),
    .divisor  (dv_d),
    .quotient (dv_q),
    .done     (dv_done)
  );

  assign f_mag = (dv_q > F_LIM) ? F_LIM : dv_q;
  assign u_q   = $signed({1'b0, dv_q[U_W-2:0]});

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.dsel)
        DSEL_A:  a_q <= dv_q[DSQ_W-1:0];
        DSEL_B:  b_q <= dv_q[TT_W-1:0];
        DSEL_F:  f   <= diff[DVN_W-1] ? -$signed(F_W'(f_mag)) : $signed(F_W'(f_mag));
        DSEL_UX: ux  <= dx[D_W-1] ? -u_q : u_q;
        DSEL_UY: uy  <= dy[D_W-1] ? -u_q : u_q;
        default: ;
      endcase
    end
    if (cmd.mul) begin
      prod <= PROD_W'(f) * PROD_W'(cmd.use_y ? uy : ux);
    end
  end

  // Truncate toward zero on the 16-bit fraction drop, then saturate.
  assign prod_adj = prod + (prod[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
  assign contrib  = prod_adj[CON_W+U_SH-1:U_SH];
  assign sum_sel  = cmd.use_y ? sum_y : sum_x;
  assign sum_raw  = (CON_W+1)'(sum_sel) + (CON_W+1)'(contrib);
  assign sum_wide = (SUM_W+1)'(sum_raw);

  always_comb begin
    if (sum_raw > (CON_W+1)'(SUM_MAX)) begin
      sum_sat = SUM_W'(SUM_MAX);
    end else if (sum_raw < (CON_W+1)'(SUM_MIN)) begin
      sum_sat = SUM_W'(SUM_MIN);
    end else begin
      sum_sat = SUM_W'(sum_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
    end else if (cmd.emit) begin
      sum_x <= '0;
      sum_y <= '0;
    end else if (cmd.acc) begin
      if (cmd.use_y) begin
        sum_y <= sum_sat;
      end else begin
        sum_x <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {sum_y, sum_x};
    end
  end

endmodule

FILE: rtl/gfa_ctrl.sv
// Sequencer of the force accumulator: handshakes and datapath commands.
// Depends on gfa_pkg.
module gfa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  gfa_pkg::stat_t stat,
  output gfa_pkg::cmd_t  cmd
);
  import gfa_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_DIFF   = 15'b000000000000010,
    S_SQ     = 15'b000000000000100,
    S_SUM    = 15'b000000000001000,
    S_ZCHK   = 15'b000000000010000,
    S_SQRT   = 15'b000000000100000,
    S_TOUCH  = 15'b000000001000000,
    S_DSTART = 15'b000000010000000,
    S_DWAIT  = 15'b000000100000000,
    S_MULX   = 15'b000001000000000,
    S_ACCX   = 15'b000010000000000,
    S_MULY   = 15'b000100000000000,
    S_ACCY   = 15'b001000000000000,
    S_FIN    = 15'b010000000000000,
    S_EMIT   = 15'b100000000000000
  } state_t;

  state_t state;
  state_t state_next;
  dsel_t  dsel;
  dsel_t  dsel_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    dsel_next      = dsel;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.dsel       = dsel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = stat.skip_early ? S_FIN : S_SQ;
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_ZCHK;
      end
      S_ZCHK: begin
        if (stat.dsq_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.sqrt_start = 1'b1;
          state_next     = S_SQRT;
        end
      end
      S_SQRT: begin
        if (stat.sqrt_done) begin
          state_next = S_TOUCH;
        end
      end
      S_TOUCH: begin
        dsel_next  = DSEL_A;
        state_next = stat.touching ? S_FIN : S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          case (dsel)
            DSEL_A:  dsel_next = DSEL_B;
            DSEL_B:  dsel_next = DSEL_F;
            DSEL_F:  dsel_next = DSEL_UX;
            DSEL_UX: dsel_next = DSEL_UY;
            default: dsel_next = DSEL_A;
          endcase
          state_next = (dsel == DSEL_UY) ? S_MULX : S_DSTART;
        end
      end
      S_MULX: begin
        cmd.mul    = 1'b1;
        state_next = S_ACCX;
      end
      S_ACCX: begin
        cmd.acc    = 1'b1;
        state_next = S_MULY;
      end
      S_MULY: begin
        cmd.mul    = 1'b1;
        cmd.use_y  = 1'b1;
        state_next = S_ACCY;
      end
      S_ACCY: begin
        cmd.acc    = 1'b1;
        cmd.use_y  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        state_next = stat.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dsel      <= DSEL_A;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      dsel      <= dsel_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: rtl/graph_layout_force_accumulator.sv
// An item that is skipped by index or target goes from the difference step
// straight to the finish step; a full item runs 25 square-root steps and
// five divisions of 51 steps each on one shared divider. One item is in work
// at a time; the result register lets the next item enter while a result
// waits. Reset (rst, synchronous) clears the sequencer, the sums and the output
// valid flag, and sets the configuration to zero with node_count at CNT_MIN.
//
// Top level of the layout force accumulator: APB register file, sequencer
// and datapath. Depends on gfa_pkg, gfa_ctrl, gfa_dp and gfa_div.
module graph_layout_force_accumulator (
  input  logic                            clk,
  input  logic                            rst,
  // Stream of other nodes.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tdata, low bit up: node_index[9:0], other_x[33:10], other_y[57:34],
  // other_radius[73:58], goal_dist[97:74], zero pad[103:98].
  input  logic [gfa_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tlast,
  // Result stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tdata, low bit up: impulse_x[39:0], impulse_y[79:40].
  output logic [gfa_pkg::OUT_TDATA_W-1:0] m_tdata,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gfa_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import gfa_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  wr_en;

  // The port never stalls; a write lands on the access cycle.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.self_x      <= '0;
      cfg.self_y      <= '0;
      cfg.self_radius <= '0;
      cfg.self_index  <= '0;
      cfg.node_count  <= CNT_MIN;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_SELF_X:   cfg.self_x      <= pwdata[POS_W-1:0];
        REG_SELF_Y:   cfg.self_y      <= pwdata[POS_W-1:0];
        REG_SELF_RAD: cfg.self_radius <= pwdata[RAD_W-1:0];
        REG_SELF_IDX: cfg.self_index  <= pwdata[IDX_W-1:0];
        REG_COUNT:    cfg.node_count  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the stored bits, zero extended.
  always_comb begin
    case (paddr[4:2])
      REG_SELF_X:   prdata = {8'h00, cfg.self_x};
      REG_SELF_Y:   prdata = {8'h00, cfg.self_y};
      REG_SELF_RAD: prdata = {16'h0000, cfg.self_radius};
      REG_SELF_IDX: prdata = {22'h000000, cfg.self_index};
      REG_COUNT:    prdata = {21'h000000, cfg.node_count};
      default:      prdata = '0;
    endcase
  end

  gfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gfa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_tdata),
    .in_last  (s_tlast),
    .out_data (m_tdata)
  );

endmodule

FILE: rtl/gfa_checker.sv
// Port-level checks for the layout force accumulator, bound to the top.
// Depends on gfa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gfa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [gfa_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import gfa_pkg::*;

  // Reset leaves no result pending.
  `GFA_ASSERT_NORST(a_reset_idle, clk, rst |=> !m_tvalid, "result valid after reset")
  // One item at a time: an accepted transaction makes the input busy.
  `GFA_ASSERT(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> !s_tready, "ready after accept")
  // A new result only comes out of the busy emit step.
  `GFA_ASSERT(a_result_from_busy, clk, rst, $rose(m_tvalid) |-> $past(!s_tready), "result while idle")
  // A stalled result holds.
  `GFA_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped")

endmodule

bind graph_layout_force_accumulator gfa_checker u_gfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
